>>> src/swsc_pkg.sv
package swsc_pkg;

  // Widths of the fields and registers.
  localparam int SEQ_W       = 32;
  localparam int CAP_W       = 6;
  localparam int TOTAL_W     = 24;
  localparam int RTX_W       = 16;
  localparam int FIN_W       = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int ALU_W       = SEQ_W + 1;

  // Default window depth of the sender.
  localparam int WINDOW_DEF  = 32;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONN_ID  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RTX      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FIN      = 3'd4;

  // Register values after reset.
  localparam logic [CAP_W-1:0]   CAPACITY_RST = 6'd8;
  localparam logic [TOTAL_W-1:0] TOTAL_RST    = 24'd0;
  localparam logic [SEQ_W-1:0]   CONN_ID_RST  = 32'd0;
  localparam logic [RTX_W-1:0]   RTX_RST      = 16'd500;
  localparam logic [FIN_W-1:0]   FIN_RST      = 24'd40000;

  // Send command kinds.
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_FIN   = 2'd1;
  localparam logic [1:0] KIND_DATA  = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  // Transfer phases.
  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_DATA  = 2'd1;
  localparam logic [1:0] PH_FIN   = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  // Input command codes and the acknowledgement header type.
  localparam logic       CMD_TICK  = 1'b0;
  localparam logic       CMD_RX    = 1'b1;
  localparam logic [1:0] RX_ACK    = 2'd3;

  // Duplicate acks of the window base that force a resend.
  localparam logic [1:0] DUP_LIMIT = 2'd3;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [SEQ_W-1:0] a;
    logic [SEQ_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] res;
    logic             ge;
    logic             eq;
  } alu_rsp_t;

  typedef struct packed {
    logic [CAP_W-1:0]   capacity;
    logic [TOTAL_W-1:0] total;
    logic [SEQ_W-1:0]   conn_id;
    logic [RTX_W-1:0]   rtx_ticks;
    logic [FIN_W-1:0]   fin_ticks;
  } cfg_t;

endpackage

>>> src/swsc_alu.sv
module swsc_alu (
  input  swsc_pkg::alu_req_t req,
  output swsc_pkg::alu_rsp_t rsp
);
  import swsc_pkg::*;

  logic [ALU_W-1:0] sum;

  // One shared add/subtract unit; compare flags come from the difference.
  always_comb begin
    if (req.op == ALU_ADD) begin
      sum = {1'b0, req.a} + {1'b0, req.b};
    end else begin
      sum = {1'b0, req.a} - {1'b0, req.b};
    end
  end

  assign rsp.res = sum;
  assign rsp.ge  = ~sum[ALU_W-1];
  assign rsp.eq  = (sum == '0);

endmodule

>>> src/swsc_seq.sv
module swsc_seq #(
  parameter int WINDOW = swsc_pkg::WINDOW_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  swsc_pkg::cfg_t             cfg,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       command,
  input  logic [1:0]                 rx_type,
  input  logic [swsc_pkg::SEQ_W-1:0] rx_seq,
  output swsc_pkg::alu_req_t         alu_req,
  input  swsc_pkg::alu_rsp_t         alu_rsp,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 send_kind,
  output logic [swsc_pkg::SEQ_W-1:0] send_seq,
  output logic [1:0]                 phase_now,
  output logic                       last
);
  import swsc_pkg::*;

  localparam int CNT_W = $clog2(WINDOW + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_DTICK,
    ST_FTICK,
    ST_FRTX,
    ST_FACK,
    ST_WREST,
    ST_WCAP,
    ST_DSUM,
    ST_DCMP,
    ST_DEND,
    ST_DNEWB,
    ST_CHK,
    ST_WSEND,
    ST_EMIT
  } state_t;

  state_t state;

  // Latched transaction fields.
  logic             cmd_r;
  logic [1:0]       typ_r;
  logic [SEQ_W-1:0] seq_r;

  // Protocol state.
  logic [1:0]         phase;
  logic               first_sent;
  logic [TOTAL_W-1:0] base;
  logic [1:0]         dup;
  logic [RTX_W-1:0]   rtx_timer;
  logic [FIN_W-1:0]   fin_count;

  // Window size and the pending sends of the current transaction.
  logic [TOTAL_W-1:0] rest_r;
  logic [TOTAL_W:0]   end_r;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   idx;
  logic               wc_burst;
  logic               em_start;
  logic               em_fin;
  logic               em_data;

  logic               accept;
  logic               out_free;
  logic               tick;
  logic               is_ack;
  logic [RTX_W-1:0]   rtx_inc;
  logic [FIN_W-1:0]   fin_inc;
  logic [CNT_W-1:0]   cap_eff;
  logic [CNT_W-1:0]   idx_inc;
  logic               data_last;

  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign tick      = (cmd_r == CMD_TICK);
  assign is_ack    = (cmd_r == CMD_RX) && (typ_r == RX_ACK);
  assign rtx_inc   = (rtx_timer == '1) ? rtx_timer : rtx_timer + 1'b1;
  assign fin_inc   = (fin_count == '1) ? fin_count : fin_count + 1'b1;
  assign idx_inc   = idx + 1'b1;
  assign data_last = (idx_inc == cnt);

  // Capacity clamped into one through the window depth.
  always_comb begin
    if (cfg.capacity == '0) begin
      cap_eff = CNT_W'(1);
    end else if ({1'b0, cfg.capacity} > (CAP_W + 1)'(WINDOW)) begin
      cap_eff = CNT_W'(WINDOW);
    end else begin
      cap_eff = CNT_W'(cfg.capacity);
    end
  end

  // Operand selection for the shared unit, one operation per step.
  always_comb begin
    alu_req.op = ALU_SUB;
    alu_req.a  = '0;
    alu_req.b  = '0;
    case (state)
      ST_START: begin
        if (tick && first_sent) begin
          alu_req.a = SEQ_W'(rtx_inc);
          alu_req.b = SEQ_W'(cfg.rtx_ticks);
        end else begin
          alu_req.a = seq_r;
          alu_req.b = cfg.conn_id;
        end
      end
      ST_DTICK, ST_FRTX: begin
        alu_req.a = SEQ_W'(rtx_inc);
        alu_req.b = SEQ_W'(cfg.rtx_ticks);
      end
      ST_FTICK: begin
        alu_req.a = SEQ_W'(fin_inc);
        alu_req.b = SEQ_W'(cfg.fin_ticks);
      end
      ST_FACK: begin
        alu_req.a = seq_r;
        alu_req.b = cfg.conn_id;
      end
      ST_WREST: begin
        alu_req.a = SEQ_W'(cfg.total);
        alu_req.b = SEQ_W'(base);
      end
      ST_WCAP: begin
        alu_req.a = SEQ_W'(rest_r);
        alu_req.b = SEQ_W'(cap_eff);
      end
      ST_DSUM: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = SEQ_W'(base);
        alu_req.b  = SEQ_W'(cnt);
      end
      ST_DCMP: begin
        alu_req.a = seq_r;
        alu_req.b = SEQ_W'(base);
      end
      ST_DEND: begin
        alu_req.a = SEQ_W'(end_r);
        alu_req.b = seq_r;
      end
      ST_DNEWB: begin
        alu_req.a = SEQ_W'(base);
        alu_req.b = SEQ_W'(cfg.total);
      end
      ST_EMIT: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = SEQ_W'(base);
        alu_req.b  = SEQ_W'(idx);
      end
      default: begin
        alu_req.op = ALU_SUB;
      end
    endcase
  end

  // Sequencer, protocol state and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      phase      <= PH_START;
      first_sent <= 1'b0;
      base       <= '0;
      dup        <= DUP_LIMIT;
      rtx_timer  <= '0;
      fin_count  <= '0;
      wc_burst   <= 1'b0;
      em_start   <= 1'b0;
      em_fin     <= 1'b0;
      em_data    <= 1'b0;
    end else begin
      // An accepted result frees the output register unless the send step refills it.
      if (out_valid && !out_stall && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cmd_r    <= command;
            typ_r    <= rx_type;
            seq_r    <= rx_seq;
            em_start <= 1'b0;
            em_fin   <= 1'b0;
            em_data  <= 1'b0;
            wc_burst <= 1'b0;
            case (phase)
              PH_START: state <= ST_START;
              PH_DATA: begin
                if (command == CMD_TICK) begin
                  state <= ST_DTICK;
                end else if (rx_type == RX_ACK) begin
                  state <= ST_WREST;
                end else begin
                  state <= ST_CHK;
                end
              end
              PH_FIN: begin
                if (command == CMD_TICK) begin
                  state <= ST_FTICK;
                end else if (rx_type == RX_ACK) begin
                  state <= ST_FACK;
                end else begin
                  state <= ST_CHK;
                end
              end
              default: state <= ST_CHK;
            endcase
          end
        end

        // START phase: first send, resend on timeout, or the START ack.
        ST_START: begin
          if (!first_sent) begin
            em_start   <= 1'b1;
            first_sent <= 1'b1;
            rtx_timer  <= '0;
          end
          if (tick && first_sent) begin
            if (alu_rsp.ge) begin
              em_start  <= 1'b1;
              rtx_timer <= '0;
            end else begin
              rtx_timer <= rtx_inc;
            end
          end else if (is_ack && alu_rsp.eq) begin
            phase     <= PH_DATA;
            dup       <= DUP_LIMIT;
            rtx_timer <= '0;
          end
          state <= ST_CHK;
        end

        // DATA phase tick: a timeout forces a window resend.
        ST_DTICK: begin
          rtx_timer <= rtx_inc;
          if (alu_rsp.ge) begin
            dup <= DUP_LIMIT;
          end
          state <= ST_CHK;
        end

        // FIN phase tick: give up on the FIN timeout, else maybe resend FIN.
        ST_FTICK: begin
          fin_count <= fin_inc;
          if (alu_rsp.ge) begin
            phase <= PH_DONE;
            state <= ST_CHK;
          end else begin
            state <= ST_FRTX;
          end
        end

        ST_FRTX: begin
          if (alu_rsp.ge) begin
            em_fin    <= 1'b1;
            rtx_timer <= '0;
          end else begin
            rtx_timer <= rtx_inc;
          end
          state <= ST_CHK;
        end

        ST_FACK: begin
          if (alu_rsp.eq) begin
            phase <= PH_DONE;
          end
          state <= ST_CHK;
        end

        // Window size, first step: packets left after the base.
        ST_WREST: begin
          if (!alu_rsp.ge || alu_rsp.eq) begin
            cnt   <= '0;
            state <= wc_burst ? ST_WSEND : ST_DSUM;
          end else begin
            rest_r <= alu_rsp.res[TOTAL_W-1:0];
            state  <= ST_WCAP;
          end
        end

        // Window size, second step: limit by the capacity.
        ST_WCAP: begin
          cnt   <= alu_rsp.ge ? cap_eff : rest_r[CNT_W-1:0];
          state <= wc_burst ? ST_WSEND : ST_DSUM;
        end

        // Ack handling: window end, then the ack against base and end.
        ST_DSUM: begin
          end_r <= alu_rsp.res[TOTAL_W:0];
          state <= ST_DCMP;
        end

        ST_DCMP: begin
          if (alu_rsp.eq) begin
            if (dup != DUP_LIMIT) begin
              dup <= dup + 1'b1;
            end
            state <= ST_CHK;
          end else if (alu_rsp.ge) begin
            state <= ST_DEND;
          end else begin
            state <= ST_CHK;
          end
        end

        ST_DEND: begin
          if (alu_rsp.ge) begin
            base  <= seq_r[TOTAL_W-1:0];
            state <= ST_DNEWB;
          end else begin
            state <= ST_CHK;
          end
        end

        // New base: every packet acknowledged starts FIN.
        ST_DNEWB: begin
          if (alu_rsp.ge) begin
            phase     <= PH_FIN;
            fin_count <= '0;
            rtx_timer <= '0;
            em_fin    <= 1'b1;
          end else begin
            dup <= DUP_LIMIT;
          end
          state <= ST_CHK;
        end

        // A window is due in DATA once the duplicate count is full.
        ST_CHK: begin
          if (phase == PH_DATA && dup == DUP_LIMIT) begin
            wc_burst <= 1'b1;
            state    <= ST_WREST;
          end else begin
            state <= ST_EMIT;
          end
        end

        ST_WSEND: begin
          if (cnt == '0) begin
            phase     <= PH_FIN;
            fin_count <= '0;
            rtx_timer <= '0;
            em_fin    <= 1'b1;
          end else begin
            em_data   <= 1'b1;
            dup       <= '0;
            rtx_timer <= '0;
            idx       <= '0;
          end
          state <= ST_EMIT;
        end

        // One send command per cycle into the output register while the output does not stall.
        ST_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (em_start) begin
              send_kind <= KIND_START;
              send_seq  <= cfg.conn_id;
              phase_now <= PH_START;
              last      <= !(em_fin || em_data);
              em_start  <= 1'b0;
              if (!(em_fin || em_data)) begin
                state <= ST_IDLE;
              end
            end else if (em_fin) begin
              send_kind <= KIND_FIN;
              send_seq  <= cfg.conn_id;
              phase_now <= PH_FIN;
              last      <= !em_data;
              em_fin    <= 1'b0;
              if (!em_data) begin
                state <= ST_IDLE;
              end
            end else if (em_data) begin
              send_kind <= KIND_DATA;
              send_seq  <= alu_rsp.res[SEQ_W-1:0];
              phase_now <= PH_DATA;
              last      <= data_last;
              idx       <= idx_inc;
              if (data_last) begin
                em_data <= 1'b0;
                state   <= ST_IDLE;
              end
            end else begin
              send_kind <= KIND_NONE;
              send_seq  <= '0;
              phase_now <= phase;
              last      <= 1'b1;
              state     <= ST_IDLE;
            end
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // A data burst never runs with an empty window or past its end.
  assert property (@(posedge clk) disable iff (rst)
    em_data |-> (cnt != '0) && (idx < cnt))
    else $error("data burst index outside the window");

  // A pending FIN send always belongs to the FIN phase.
  assert property (@(posedge clk) disable iff (rst)
    em_fin |-> (phase == PH_FIN))
    else $error("FIN send pending outside the FIN phase");

  // The finished phase is final.
  assert property (@(posedge clk) disable iff (rst)
    ($past(phase) == PH_DONE) |-> (phase == PH_DONE))
    else $error("left the finished phase");

  // An accepted transaction always starts the sequencer.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != ST_IDLE))
    else $error("transaction accepted without work");

endmodule

>>> src/sliding_window_sender_control.sv
// Channel  | Valid      | Stall       | Payload
// ---------+------------+-------------+--------------------------------------------
// input    | in_valid   | in_stall    | command, rx_type, rx_seq
// output   | out_valid  | out_stall   | send_kind, send_seq, phase_now, last
// config   | cfg_en     | (none)      | cfg_index, cfg_data
//
// A transaction is accepted, then decided in steps on the shared add/subtract
// unit; its results enter the output register one per cycle while the output
// does not stall. Input is stalled until the last result of a transaction sits
// in the output register. Output stalls hold the sequencer in its send step.
// Synchronous reset restores register defaults and puts the transfer in the
// START phase.
module sliding_window_sender_control #(
  parameter int WINDOW = swsc_pkg::WINDOW_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_en,
  input  logic [swsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [swsc_pkg::SEQ_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           command,
  input  logic [1:0]                     rx_type,
  input  logic [swsc_pkg::SEQ_W-1:0]     rx_seq,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     send_kind,
  output logic [swsc_pkg::SEQ_W-1:0]     send_seq,
  output logic [1:0]                     phase_now,
  output logic                           last
);
  import swsc_pkg::*;

  cfg_t     cfg;
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.capacity  <= CAPACITY_RST;
      cfg.total     <= TOTAL_RST;
      cfg.conn_id   <= CONN_ID_RST;
      cfg.rtx_ticks <= RTX_RST;
      cfg.fin_ticks <= FIN_RST;
    end else if (cfg_en) begin
      case (cfg_index)
        REG_CAPACITY: cfg.capacity  <= cfg_data[CAP_W-1:0];
        REG_TOTAL:    cfg.total     <= cfg_data[TOTAL_W-1:0];
        REG_CONN_ID:  cfg.conn_id   <= cfg_data;
        REG_RTX:      cfg.rtx_ticks <= cfg_data[RTX_W-1:0];
        REG_FIN:      cfg.fin_ticks <= cfg_data[FIN_W-1:0];
        default:      cfg.capacity  <= cfg.capacity;
      endcase
    end
  end

  swsc_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  swsc_seq #(
    .WINDOW (WINDOW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .rx_type   (rx_type),
    .rx_seq    (rx_seq),
    .alu_req   (alu_req),
    .alu_rsp   (alu_rsp),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .send_kind (send_kind),
    .send_seq  (send_seq),
    .phase_now (phase_now),
    .last      (last)
  );

endmodule
